// File: hw/rtl/wildcard_byte_pattern_search_unit_defines.svh
// Assertion macros for the wildcard byte pattern search unit.
// The asserting module must have signals named clk and rst in scope.
`ifndef WILDCARD_BYTE_PATTERN_SEARCH_UNIT_DEFINES_SVH
`define WILDCARD_BYTE_PATTERN_SEARCH_UNIT_DEFINES_SVH

// same-cycle implication
`define WBPS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define WBPS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/wbps_pkg.sv
`timescale 1ns / 1ps

package wbps_pkg;

  localparam int MAX_PATTERN_DEF = 64;
  localparam int CMD_DEPTH = 4;
  localparam int RES_DEPTH = 2;

  localparam logic REG_PATTERN_LENGTH = 1'b0;
  localparam logic REG_BASE_ADDRESS   = 1'b1;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_SCAN,
    OP_SKIP
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [5:0] entry_index;
    logic [7:0] pattern_byte;
    logic       care;
    logic [7:0] data_byte;
    logic       last_byte;
  } cmd_t;

  typedef struct packed {
    logic        found;
    logic [31:0] match_address;
  } res_t;

endpackage

// File: hw/rtl/wildcard_byte_pattern_search_unit.sv
`timescale 1ns / 1ps
// Wildcard byte pattern search unit.
// Input queue: push/full. Each transaction is either a pattern load
// (func 0: entry_index, pattern_byte, care) or a stream byte (func 1:
// data_byte, last_byte). Result queue: empty/pop, carrying found and
// match_address; at most one result per scanned region.
// Config channel: cfg_valid/cfg_ready (ready is always high), cfg_index
// selects pattern_length or base_address. Write config only while idle.
// Throughput: one transaction per cycle while the result queue is not full,
// set by the shift-and update of the match vector against all entries at once.
// A result passes from the push of the byte that causes it through the
// command queue, then the result queue, before it can be popped.
// Reset clears both queues, the scan state, pattern_length to 1 and
// base_address to 0; pattern entries hold garbage until loaded.
// If the receiver stalls, the 2-entry result queue fills, the back end
// stops draining the 4-entry command queue, and full rises once that fills.
module wildcard_byte_pattern_search_unit import wbps_pkg::*; #(
  parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic        func,
  input  logic [5:0]  entry_index,
  input  logic [7:0]  pattern_byte,
  input  logic        care,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        empty,
  input  logic        pop,
  output logic        found,
  output logic [31:0] match_address,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  logic [6:0]  pattern_length;
  logic [31:0] base_address;
  logic        cmd_valid;
  logic        cmd_pop;
  cmd_t        cmd;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length <= 7'd1;
      base_address   <= 32'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PATTERN_LENGTH: pattern_length <= cfg_data[6:0];
        REG_BASE_ADDRESS:   base_address   <= cfg_data;
        default:            base_address   <= base_address;
      endcase
    end
  end

  wbps_front #(
    .MAX_PATTERN(MAX_PATTERN)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .func        (func),
    .entry_index (entry_index),
    .pattern_byte(pattern_byte),
    .care        (care),
    .data_byte   (data_byte),
    .last_byte   (last_byte),
    .cmd_pop     (cmd_pop),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd)
  );

  wbps_back #(
    .MAX_PATTERN(MAX_PATTERN)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .pattern_length(pattern_length),
    .base_address  (base_address),
    .cmd_valid     (cmd_valid),
    .cmd           (cmd),
    .cmd_pop       (cmd_pop),
    .pop           (pop),
    .empty         (empty),
    .found         (found),
    .match_address (match_address)
  );

endmodule

// File: hw/rtl/wbps_fifo.sv
`timescale 1ns / 1ps

module wbps_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      case ({do_wr, do_rd})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// File: hw/rtl/wbps_front.sv
`timescale 1ns / 1ps

module wbps_front import wbps_pkg::*; #(
  parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic       func,
  input  logic [5:0] entry_index,
  input  logic [7:0] pattern_byte,
  input  logic       care,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  input  logic       cmd_pop,
  output logic       cmd_valid,
  output cmd_t       cmd
);

  cmd_t cmd_in;
  logic cmd_empty;

  // loads past the pattern store become skips here; the back end pops them unwritten
  always_comb begin
    cmd_in.entry_index  = entry_index;
    cmd_in.pattern_byte = pattern_byte;
    cmd_in.care         = care;
    cmd_in.data_byte    = data_byte;
    cmd_in.last_byte    = last_byte;
    if (func) begin
      cmd_in.op = OP_SCAN;
    end else if (32'(entry_index) < MAX_PATTERN) begin
      cmd_in.op = OP_LOAD;
    end else begin
      cmd_in.op = OP_SKIP;
    end
  end

  wbps_fifo #(
    .WIDTH($bits(cmd_t)),
    .DEPTH(CMD_DEPTH)
  ) u_cmd_fifo (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (push),
    .wr_data(cmd_in),
    .full   (full),
    .rd_en  (cmd_pop),
    .rd_data(cmd),
    .empty  (cmd_empty)
  );

  assign cmd_valid = !cmd_empty;

endmodule

// File: hw/rtl/wbps_back.sv
`timescale 1ns / 1ps
`include "wildcard_byte_pattern_search_unit_defines.svh"

module wbps_back import wbps_pkg::*; #(
  parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [6:0]  pattern_length,
  input  logic [31:0] base_address,
  input  logic        cmd_valid,
  input  cmd_t        cmd,
  output logic        cmd_pop,
  input  logic        pop,
  output logic        empty,
  output logic        found,
  output logic [31:0] match_address
);

  logic [7:0]             pattern_bytes [MAX_PATTERN];
  logic                   care_bits [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] pm;
  logic [MAX_PATTERN-1:0] pm_next;
  logic [MAX_PATTERN-1:0] act_mask;
  logic [MAX_PATTERN-1:0] last_mask;
  logic [31:0]            pos;
  logic [31:0]            bias;
  logic                   done;
  logic [31:0]            len32;
  logic                   res_full;
  logic                   res_push;
  logic                   scan_take;
  logic                   load_take;
  logic                   hit;
  res_t                   res_in;
  res_t                   res_out;

  // clamp length to 1..MAX_PATTERN
  always_comb begin
    if (pattern_length == 7'd0) begin
      len32 = 32'd1;
    end else if (32'(pattern_length) > MAX_PATTERN) begin
      len32 = 32'(MAX_PATTERN);
    end else begin
      len32 = 32'(pattern_length);
    end
  end

  // config must stay static while busy (not enforced here), so masks and bias
  // are registered off it; the command queue lets them settle after a write
  always_ff @(posedge clk) begin
    bias <= base_address + 32'd1 - len32;
  end

  assign cmd_pop   = cmd_valid && !res_full;
  assign scan_take = cmd_pop && (cmd.op == OP_SCAN);
  assign load_take = cmd_pop && (cmd.op == OP_LOAD);

  always_ff @(posedge clk) begin
    for (int k = 0; k < MAX_PATTERN; k++) begin
      act_mask[k]  <= (32'(k) < len32);
      last_mask[k] <= (32'(k) + 32'd1 == len32);
      if (load_take && (32'(cmd.entry_index) == 32'(k))) begin
        pattern_bytes[k] <= cmd.pattern_byte;
        care_bits[k]     <= cmd.care;
      end
    end
  end

  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_entry
    logic prev;
    logic eq;

    if (k == 0) begin : g_first
      assign prev = 1'b1;
    end else begin : g_rest
      assign prev = pm[k-1];
    end

    assign eq         = !care_bits[k] || (pattern_bytes[k] == cmd.data_byte);
    assign pm_next[k] = act_mask[k] && prev && eq;
  end

  assign hit      = |(pm_next & last_mask);
  assign res_push = scan_take && !done && (hit || cmd.last_byte);

  always_comb begin
    res_in.found         = hit;
    res_in.match_address = hit ? (bias + pos) : 32'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pm   <= '0;
      pos  <= '0;
      done <= 1'b0;
    end else if (scan_take) begin
      if (cmd.last_byte) begin
        pm   <= '0;
        pos  <= '0;
        done <= 1'b0;
      end else if (!done) begin
        pm   <= pm_next;
        pos  <= pos + 32'd1;
        done <= hit;
      end
    end
  end

  wbps_fifo #(
    .WIDTH($bits(res_t)),
    .DEPTH(RES_DEPTH)
  ) u_res_fifo (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (res_push),
    .wr_data(res_in),
    .full   (res_full),
    .rd_en  (pop),
    .rd_data(res_out),
    .empty  (empty)
  );

  assign found         = res_out.found;
  assign match_address = res_out.match_address;

  `WBPS_ASSERT_NOW(a_res_from_live_scan, res_push, scan_take && !done,
    "result pushed without a live scan")
  `WBPS_ASSERT_NOW(a_miss_zero_addr, res_push && !res_in.found,
    res_in.match_address == 32'd0, "not-found result carries an address")
  `WBPS_ASSERT_NEXT(a_done_after_hit, res_push && res_in.found && !cmd.last_byte,
    done, "search not closed after a match")
  `WBPS_ASSERT_NEXT(a_clear_on_last, scan_take && cmd.last_byte,
    (pm == '0) && (pos == 32'd0) && !done, "scan state not cleared at region end")

endmodule
